>>> rtl/plrr_pkg.sv
// Package for the point/line reprojection residual block.
// Holds payload structs, register indexes and widths; no dependencies.
package plrr_pkg;

  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned NumRegs       = 6;
  localparam int unsigned CfgIdxW       = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic        op;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] pw;
    logic [31:0] obs_u;
    logic [31:0] obs_v;
    logic [31:0] line_a;
    logic [31:0] line_b;
    logic [31:0] line_c;
  } plrr_in_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] residual_first;
    logic [31:0] residual_second;
    logic        depth_zero;
    logic        saturated;
  } plrr_out_t;

endpackage

>>> rtl/point_line_reprojection_residual_top.sv
// Top level of the point/line reprojection residual block.
// Uses plrr_pkg. Matrix multiply, pipelined restoring divider, line MAC, saturation.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------
//  input     | start_i, busy_o     | in_i  (plrr_in_t)
//  result    | done_o strobe       | out_o (plrr_out_t)
//  config    | cfg_valid/ready     | cfg_index_i, cfg_data_i
//
// One item is taken per cycle; busy_o stays low. done_o rises once the item has passed
// stages 1 to 3, the divider stages, stage L1 and the L2 output register; the divider
// retires one quotient bit per stage for both u and v. Reset clears all valid bits and the
// matrix registers. The receiver cannot stall, so the pipeline never holds.
module point_line_reprojection_residual_top
  import plrr_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  plrr_in_t          in_i,
  output logic              done_o,
  output plrr_out_t         out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]       cfg_data_i
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned PW  = 2 * CW;            // product width
  localparam int unsigned TW  = PW - FRAC_BITS + 3; // sum of four truncated products
  localparam int unsigned NW  = TW + FRAC_BITS;    // dividend magnitude bits
  localparam int unsigned QW  = CW + 1;            // clamped quotient magnitude bits
  localparam int unsigned DS  = QW;                // quotient-bit divider stages
  localparam int unsigned LMW = PW + 2;            // line product width
  localparam int unsigned LSW = LMW + 2;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  logic [63:0] cfg_q [NumRegs];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) cfg_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROW0_C01: cfg_q[0] <= cfg_data_i;
        REG_ROW0_C23: cfg_q[1] <= cfg_data_i;
        REG_ROW1_C01: cfg_q[2] <= cfg_data_i;
        REG_ROW1_C23: cfg_q[3] <= cfg_data_i;
        REG_ROW2_C01: cfg_q[4] <= cfg_data_i;
        REG_ROW2_C23: cfg_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic signed [CW-1:0] mel(input logic [63:0] r, input logic hi);
    mel = hi ? $signed(r[32 +: CW]) : $signed(r[0 +: CW]);
  endfunction

  // Truncate-toward-zero shift of a signed product.
  function automatic logic signed [PW-FRAC_BITS:0] trunc(input logic signed [PW-1:0] p);
    logic [PW-1:0] m;
    logic [PW-1:0] s;
    m = p[PW-1] ? PW'(-p) : PW'(p);
    s = m >> FRAC_BITS;
    trunc = p[PW-1] ? -$signed({1'b0, s[PW-FRAC_BITS-1:0]})
                    : $signed({1'b0, s[PW-FRAC_BITS-1:0]});
  endfunction

  typedef struct packed {
    logic        op;
    logic [CW-1:0] ou;
    logic [CW-1:0] ov;
    logic [CW-1:0] la;
    logic [CW-1:0] lb;
    logic [CW-1:0] lc;
  } side_t;

  // Stage 1: twelve products.
  logic             v1_q;
  side_t            s1_q;
  logic signed [PW-1:0] p1_q [3][4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] x [4];
    x[0] = $signed(in_i.px[CW-1:0]);
    x[1] = $signed(in_i.py[CW-1:0]);
    x[2] = $signed(in_i.pz[CW-1:0]);
    x[3] = $signed(in_i.pw[CW-1:0]);
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 4; j++) begin
        p1_q[k][j] <= PW'(mel(cfg_q[2*k + j/2], j[0]) * x[j]);
      end
    end
    s1_q <= '{op: in_i.op, ou: in_i.obs_u[CW-1:0], ov: in_i.obs_v[CW-1:0],
              la: in_i.line_a[CW-1:0], lb: in_i.line_b[CW-1:0], lc: in_i.line_c[CW-1:0]};
  end

  // Stage 2: sums of truncated products.
  logic             v2_q;
  side_t            s2_q;
  logic signed [TW-1:0] t2_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      t2_q[k] <= TW'(trunc(p1_q[k][0])) + TW'(trunc(p1_q[k][1]))
               + TW'(trunc(p1_q[k][2])) + TW'(trunc(p1_q[k][3]));
    end
    s2_q <= s1_q;
  end

  // Stage 3: magnitudes, signs, zero-depth check, divider setup.
  typedef struct packed {
    logic          op;
    logic          dz;
    logic          nu;
    logic          nv;
    logic          cu;
    logic          cv;
  } ctl_t;

  logic           v3_q;
  side_t          s3_q;
  ctl_t           c3_q;
  logic [NW-1:0]  nu3_q, nv3_q;
  logic [TW-1:0]  d3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    logic [TW-1:0] mu, mv, md;
    mu = t2_q[0][TW-1] ? TW'(-t2_q[0]) : TW'(t2_q[0]);
    mv = t2_q[1][TW-1] ? TW'(-t2_q[1]) : TW'(t2_q[1]);
    md = t2_q[2][TW-1] ? TW'(-t2_q[2]) : TW'(t2_q[2]);
    d3_q  <= md;
    nu3_q <= {mu, {FRAC_BITS{1'b0}}};
    nv3_q <= {mv, {FRAC_BITS{1'b0}}};
    c3_q  <= '{op: s2_q.op, dz: (t2_q[2] == '0),
               nu: t2_q[0][TW-1] ^ t2_q[2][TW-1],
               nv: t2_q[1][TW-1] ^ t2_q[2][TW-1], cu: 1'b0, cv: 1'b0};
    s3_q  <= s2_q;
  end

  // Divider: first stage tests whether the quotient exceeds QW bits, then one bit per stage.
  logic          vd_q [DS+1];
  side_t         sd_q [DS+1];
  ctl_t          cd_q [DS+1];
  logic [NW-1:0] ru_q [DS+1], rv_q [DS+1];
  logic [TW-1:0] dd_q [DS+1];
  logic [QW-1:0] qu_q [DS+1], qv_q [DS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DS; i++) vd_q[i] <= 1'b0;
    end else begin
      vd_q[0] <= v3_q;
      for (int i = 1; i <= DS; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NW+QW-1:0] du;
    ctl_t c;
    du = {{(FRAC_BITS+QW){1'b0}}, d3_q} << QW;
    c  = c3_q;
    c.cu = c3_q.dz ? 1'b0 : ({{QW{1'b0}}, nu3_q} >= du);
    c.cv = c3_q.dz ? 1'b0 : ({{QW{1'b0}}, nv3_q} >= du);
    cd_q[0] <= c;
    sd_q[0] <= s3_q;
    ru_q[0] <= nu3_q;
    rv_q[0] <= nv3_q;
    dd_q[0] <= d3_q;
    qu_q[0] <= '0;
    qv_q[0] <= '0;
    for (int i = 1; i <= DS; i++) begin
      logic [NW+QW-1:0] sh;
      sh = {{(FRAC_BITS+QW){1'b0}}, dd_q[i-1]} << (DS - i);
      if ({{QW{1'b0}}, ru_q[i-1]} >= sh) begin
        ru_q[i] <= NW'({{QW{1'b0}}, ru_q[i-1]} - sh);
        qu_q[i] <= {qu_q[i-1][QW-2:0], 1'b1};
      end else begin
        ru_q[i] <= ru_q[i-1];
        qu_q[i] <= {qu_q[i-1][QW-2:0], 1'b0};
      end
      if ({{QW{1'b0}}, rv_q[i-1]} >= sh) begin
        rv_q[i] <= NW'({{QW{1'b0}}, rv_q[i-1]} - sh);
        qv_q[i] <= {qv_q[i-1][QW-2:0], 1'b1};
      end else begin
        rv_q[i] <= rv_q[i-1];
        qv_q[i] <= {qv_q[i-1][QW-2:0], 1'b0};
      end
      cd_q[i] <= cd_q[i-1];
      sd_q[i] <= sd_q[i-1];
      dd_q[i] <= dd_q[i-1];
    end
  end

  // Clamp: quotient magnitude limit is 2^(CW+1)-1, i.e. all ones of QW bits.
  logic signed [QW:0] u_w, v_w;
  always_comb begin
    logic [QW-1:0] mu, mv;
    mu  = cd_q[DS].cu ? '1 : qu_q[DS];
    mv  = cd_q[DS].cv ? '1 : qv_q[DS];
    u_w = cd_q[DS].nu ? -$signed({1'b0, mu}) : $signed({1'b0, mu});
    v_w = cd_q[DS].nv ? -$signed({1'b0, mv}) : $signed({1'b0, mv});
  end

  // Stage L1: line products and point differences.
  logic          vl1_q;
  side_t         sl1_q;
  ctl_t          cl1_q;
  logic signed [LMW-1:0] pa_q, pb_q;
  logic signed [QW+1:0]  du_q, dv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vl1_q <= 1'b0;
    else         vl1_q <= vd_q[DS];
  end
  always_ff @(posedge clk_i) begin
    pa_q  <= LMW'($signed(sd_q[DS].la) * u_w);
    pb_q  <= LMW'($signed(sd_q[DS].lb) * v_w);
    du_q  <= (QW+2)'($signed(sd_q[DS].ou)) - (QW+2)'(u_w);
    dv_q  <= (QW+2)'($signed(sd_q[DS].ov)) - (QW+2)'(v_w);
    sl1_q <= sd_q[DS];
    cl1_q <= cd_q[DS];
  end

  function automatic logic signed [LMW-FRAC_BITS:0] truncl(input logic signed [LMW-1:0] p);
    logic [LMW-1:0] m;
    logic [LMW-1:0] s;
    m = p[LMW-1] ? LMW'(-p) : LMW'(p);
    s = m >> FRAC_BITS;
    truncl = p[LMW-1] ? -$signed({1'b0, s[LMW-FRAC_BITS-1:0]})
                      : $signed({1'b0, s[LMW-FRAC_BITS-1:0]});
  endfunction

  // Stage L2: line sum or point differences, saturation, output register.
  localparam logic signed [LSW-1:0] Hi = LSW'((64'sd1 <<< (CW-1)) - 1);
  localparam logic signed [LSW-1:0] Lo = -Hi - 1;

  plrr_out_t out_d, out_q;
  logic      done_q;
  always_comb begin
    logic signed [LSW-1:0] r1, r2;
    logic                  clip;
    clip = cl1_q.cu | cl1_q.cv;
    if (cl1_q.op) begin
      r1 = LSW'(truncl(pa_q)) + LSW'(truncl(pb_q)) - LSW'($signed(sl1_q.lc));
      r2 = '0;
    end else begin
      r1 = LSW'(du_q);
      r2 = LSW'(dv_q);
    end
    if (r1 > Hi) begin r1 = Hi; clip = 1'b1; end
    else if (r1 < Lo) begin r1 = Lo; clip = 1'b1; end
    if (r2 > Hi) begin r2 = Hi; clip = 1'b1; end
    else if (r2 < Lo) begin r2 = Lo; clip = 1'b1; end
    if (cl1_q.dz) begin
      r1   = Hi;
      r2   = cl1_q.op ? '0 : Hi;
      clip = 1'b1;
    end
    out_d.kind            = cl1_q.op;
    out_d.residual_first  = 32'($signed(r1[CW-1:0]));
    out_d.residual_second = 32'($signed(r2[CW-1:0]));
    out_d.depth_zero      = cl1_q.dz;
    out_d.saturated       = clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= vl1_q;
  end
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

>>> rtl/plrr_checker.sv
// Port-level checker for the reprojection residual block, bound to the top level.
// Uses plrr_pkg.
module plrr_checker
  import plrr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      busy_o,
  input logic      done_o,
  input plrr_out_t out_o,
  input logic      cfg_ready_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config not ready");
  a_dz_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_o.depth_zero |-> out_o.saturated)
    else $error("zero depth without saturated");
  a_line_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_o.kind |-> out_o.residual_second == '0)
    else $error("line result with nonzero second residual");

endmodule

bind point_line_reprojection_residual_top plrr_checker u_plrr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .busy_o(busy_o), .done_o(done_o),
  .out_o(out_o), .cfg_ready_o(cfg_ready_o)
);

>>> test/tb.sv
// Testbench for point_line_reprojection_residual_top: directed and random items checked
// against a fixed-point projection predictor. Depends on plrr_pkg and the top module.
module tb;
  import plrr_pkg::*;

  localparam int FB = 16;
  localparam int CW = 32;
  localparam int LATENCY = FB + CW + 9;
  localparam longint LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  plrr_in_t in_i = '0;
  logic done_o;
  plrr_out_t out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  logic [63:0] matrix_regs [NumRegs];
  plrr_out_t residual_q [$];
  int errors = 0;
  longint cycles = 0;

  point_line_reprojection_residual_top uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint sx(logic [31:0] w);
    return longint'(signed'(w));
  endfunction

  function automatic longint magn(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned m;
    m = (longint'(magn(a)) * longint'(magn(b))) >> FB;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_div(longint n, longint d, ref bit clip);
    longint unsigned lim, un, ud, qi, r, q;
    lim = (64'd1 << (CW + 1)) - 1;
    un = magn(n);
    ud = magn(d);
    qi = un / ud;
    r = un % ud;
    if (qi > (lim >> FB)) begin
      q = lim;
      clip = 1'b1;
    end else begin
      q = qi;
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r = r - ud;
          q = q | 1;
        end
      end
      if (q > lim) begin
        q = lim;
        clip = 1'b1;
      end
    end
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat32(longint x, ref bit clip);
    longint hi, lo;
    hi = 64'sd2147483647;
    lo = -hi - 1;
    if (x > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (x < lo) begin
      clip = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic longint coeff(int r, int c);
    logic [63:0] w;
    w = matrix_regs[r * 2 + c / 2];
    return sx((c % 2) ? w[63:32] : w[31:0]);
  endfunction

  function automatic plrr_out_t project_residual(plrr_in_t it);
    plrr_out_t o;
    longint pt [4];
    longint t [3];
    longint u, v, r1, r2;
    bit clip, dz;
    clip = 1'b0;
    dz = 1'b0;
    pt[0] = sx(it.px);
    pt[1] = sx(it.py);
    pt[2] = sx(it.pz);
    pt[3] = sx(it.pw);
    for (int k = 0; k < 3; k++) begin
      t[k] = 0;
      for (int j = 0; j < 4; j++) t[k] += fx_mul(coeff(k, j), pt[j]);
    end
    if (t[2] == 0) begin
      dz = 1'b1;
      clip = 1'b1;
      r1 = 64'sd2147483647;
      r2 = it.op ? 0 : 64'sd2147483647;
    end else begin
      u = fx_div(t[0], t[2], clip);
      v = fx_div(t[1], t[2], clip);
      if (!it.op) begin
        r1 = sat32(sx(it.obs_u) - u, clip);
        r2 = sat32(sx(it.obs_v) - v, clip);
      end else begin
        r1 = sat32(fx_mul(sx(it.line_a), u) + fx_mul(sx(it.line_b), v) - sx(it.line_c),
                   clip);
        r2 = 0;
      end
    end
    o.kind = it.op;
    o.residual_first = r1[31:0];
    o.residual_second = r2[31:0];
    o.depth_zero = dz;
    o.saturated = clip;
    return o;
  endfunction

  always @(posedge clk_i) begin
    plrr_out_t exp_res;
    if (done_o) begin
      if (residual_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_o);
        errors++;
      end else begin
        exp_res = residual_q.pop_front();
        if (out_o.kind !== exp_res.kind) begin
          $display("%0t: kind expected %h actual %h", $time, exp_res.kind, out_o.kind);
          errors++;
        end
        if (out_o.residual_first !== exp_res.residual_first) begin
          $display("%0t: residual_first expected %h actual %h", $time,
                   exp_res.residual_first, out_o.residual_first);
          errors++;
        end
        if (out_o.residual_second !== exp_res.residual_second) begin
          $display("%0t: residual_second expected %h actual %h", $time,
                   exp_res.residual_second, out_o.residual_second);
          errors++;
        end
        if (out_o.depth_zero !== exp_res.depth_zero) begin
          $display("%0t: depth_zero expected %h actual %h", $time,
                   exp_res.depth_zero, out_o.depth_zero);
          errors++;
        end
        if (out_o.saturated !== exp_res.saturated) begin
          $display("%0t: saturated expected %h actual %h", $time,
                   exp_res.saturated, out_o.saturated);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    matrix_regs[idx] = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (residual_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_item(plrr_in_t it, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 18) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (busy_o);
    residual_q.push_back(project_residual(it));
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 8) << 16;
      4: return $urandom() >>> $urandom_range(0, 24);
      default: return $urandom();
    endcase
  endfunction

  function automatic plrr_in_t rnd_item();
    plrr_in_t it;
    it.op = 1'($urandom_range(0, 1));
    it.px = rnd_coord();
    it.py = rnd_coord();
    it.pz = rnd_coord();
    it.pw = ($urandom_range(0, 2) == 0) ? rnd_coord() : 32'h0001_0000;
    it.obs_u = rnd_coord();
    it.obs_v = rnd_coord();
    it.line_a = rnd_coord();
    it.line_b = rnd_coord();
    it.line_c = rnd_coord();
    return it;
  endfunction

  function automatic logic [63:0] rnd_pair(bit modest);
    logic [31:0] lo, hi;
    lo = modest ? ($urandom() >>> $urandom_range(8, 14)) : rnd_coord();
    hi = modest ? ($urandom() >>> $urandom_range(8, 14)) : rnd_coord();
    return {hi, lo};
  endfunction

  task automatic load_camera(bit modest);
    write_reg(REG_ROW0_C01, rnd_pair(modest));
    write_reg(REG_ROW0_C23, rnd_pair(modest));
    write_reg(REG_ROW1_C01, rnd_pair(modest));
    write_reg(REG_ROW1_C23, rnd_pair(modest));
    write_reg(REG_ROW2_C01, rnd_pair(modest));
    write_reg(REG_ROW2_C23, rnd_pair(modest));
  endtask

  task automatic test_reset_matrix();
    plrr_in_t it;
    it = rnd_item();
    it.op = 1'b0;
    send_item(it, 1'b0);
    it.op = 1'b1;
    send_item(it, 1'b0);
    drain();
  endtask

  task automatic test_directed();
    plrr_in_t it;
    // Identity camera with unit depth.
    write_reg(REG_ROW0_C01, 64'h0000_0000_0001_0000);
    write_reg(REG_ROW0_C23, 64'h0);
    write_reg(REG_ROW1_C01, 64'h0001_0000_0000_0000);
    write_reg(REG_ROW1_C23, 64'h0);
    write_reg(REG_ROW2_C01, 64'h0);
    write_reg(REG_ROW2_C23, 64'h0001_0000_0000_0000);
    it = '0;
    it.px = 32'h0002_0000;
    it.py = 32'hfffd_0000;
    it.pw = 32'h0001_0000;
    it.obs_u = 32'h0001_8000;
    it.obs_v = 32'h7fffffff;
    send_item(it, 1'b0);
    it.op = 1'b1;
    it.line_a = 32'h0001_0000;
    it.line_b = 32'hffff_0000;
    it.line_c = 32'h8000_0000;
    send_item(it, 1'b0);
    it.pw = 32'h0;
    send_item(it, 1'b0);
    it.op = 1'b0;
    send_item(it, 1'b0);
    it.pw = 32'h0000_0001;
    it.px = 32'h7fffffff;
    it.py = 32'h80000000;
    send_item(it, 1'b0);
    it.op = 1'b1;
    it.line_a = 32'h7fffffff;
    it.line_b = 32'h7fffffff;
    send_item(it, 1'b0);
    it.obs_u = 32'h80000000;
    it.obs_v = 32'h80000000;
    it.op = 1'b0;
    it.pw = 32'hffff_0000;
    send_item(it, 1'b0);
    it = '1;
    send_item(it, 1'b0);
    it.op = 1'b0;
    send_item(it, 1'b0);
    drain();
    write_reg(REG_ROW0_C01, 64'h7fffffff_80000000);
    write_reg(REG_ROW0_C23, 64'h80000000_7fffffff);
    write_reg(REG_ROW1_C01, 64'hffffffff_ffffffff);
    write_reg(REG_ROW1_C23, 64'h7fffffff_7fffffff);
    write_reg(REG_ROW2_C01, 64'h80000000_80000000);
    write_reg(REG_ROW2_C23, 64'h00000001_00000001);
    for (int i = 0; i < 8; i++) send_item(rnd_item(), 1'b0);
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        drain();
        load_camera(i % 300 != 200);
      end
      send_item(rnd_item(), (i / 50) % 4 != 3);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < NumRegs; i++) matrix_regs[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_matrix();
    test_directed();
    test_random(830);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
